// ----- rtl/core/etbs_pkg.sv -----
package etbs_pkg;

  localparam int SIDE_W     = 11;
  localparam int SAMPLE_W   = 16;
  localparam int ALT_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_PRESENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOID_CODE    = 2'd2;

  localparam logic [SIDE_W-1:0]   SIDE_RESET = 11'd1201;
  localparam logic [SIDE_W-1:0]   SIDE_MIN   = 11'd2;
  localparam logic [SAMPLE_W-1:0] VOID_RESET = 16'h8000;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_RD00,
    SQ_RD10,
    SQ_RD01,
    SQ_RD11,
    SQ_WR
  } seq_state_t;

  typedef enum logic [1:0] {
    TAP_00,
    TAP_10,
    TAP_01,
    TAP_11
  } tap_t;

  typedef struct packed {
    logic a_vld;
    logic b_vld;
  } fe_status_t;

  typedef struct packed {
    logic                empty;
    logic [QCNT_W-1:0]   count;
  } q_status_t;

endpackage

// ----- rtl/core/etbs_front.sv -----
module etbs_front #(
  parameter int MAX_SIDE    = 1201,
  parameter int FRAC_BITS   = 20,
  parameter int WEIGHT_BITS = 16,
  localparam int DEPTH      = MAX_SIDE * MAX_SIDE,
  localparam int ADDR_W     = $clog2(DEPTH),
  localparam int ENTRY_W    = ADDR_W + 2 * WEIGHT_BITS + etbs_pkg::SAMPLE_W
                              + etbs_pkg::SIDE_W + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          in_kind,
  input  logic [20:0]                   in_load_index,
  input  logic [etbs_pkg::SAMPLE_W-1:0] in_sample_word,
  input  logic [FRAC_BITS-1:0]          in_lat_frac,
  input  logic [FRAC_BITS-1:0]          in_lon_frac,
  input  logic [etbs_pkg::SIDE_W-1:0]   tile_side,
  input  logic                          tile_present,
  output logic                          push,
  output logic [ENTRY_W-1:0]            push_data,
  output etbs_pkg::fe_status_t          status
);

  localparam int SW  = etbs_pkg::SIDE_W;
  localparam int P_W = FRAC_BITS + SW;
  localparam int R_W = 2 * SW;

  logic [SW-1:0]  side_c;
  logic [SW-1:0]  span;

  logic                          a_vld_r;
  logic                          a_keep_r;
  logic                          a_kind_r;
  logic                          a_nt_r;
  logic [20:0]                   a_idx_r;
  logic [etbs_pkg::SAMPLE_W-1:0] a_data_r;
  logic [SW-1:0]                 a_side_r;
  logic [P_W-1:0]                a_px_r;
  logic [P_W-1:0]                a_py_r;

  logic [SW-1:0]          ix;
  logic [SW-1:0]          iy;
  logic [SW-1:0]          row;
  logic [FRAC_BITS-1:0]   frx;
  logic [FRAC_BITS-1:0]   fry;
  logic [WEIGHT_BITS-1:0] wx;
  logic [WEIGHT_BITS-1:0] wy;

  logic                          b_vld_r;
  logic                          b_kind_r;
  logic                          b_nt_r;
  logic [20:0]                   b_idx_r;
  logic [etbs_pkg::SAMPLE_W-1:0] b_data_r;
  logic [SW-1:0]                 b_side_r;
  logic [SW-1:0]                 b_ix_r;
  logic [R_W-1:0]                b_rowp_r;
  logic [WEIGHT_BITS-1:0]        b_wx_r;
  logic [WEIGHT_BITS-1:0]        b_wy_r;
  logic [ADDR_W-1:0]             b_addr;

  always_comb begin
    priority if (tile_side < etbs_pkg::SIDE_MIN) begin
      side_c = etbs_pkg::SIDE_MIN;
    end else if (32'(tile_side) > MAX_SIDE) begin
      side_c = SW'(MAX_SIDE);
    end else begin
      side_c = tile_side;
    end
    span = side_c - SW'(1);
  end

  // stage A: scale both fractions by side - 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind_r <= in_kind;
      a_keep_r <= (in_kind == etbs_pkg::KIND_QUERY) || (32'(in_load_index) < DEPTH);
      a_nt_r   <= !tile_present;
      a_idx_r  <= in_load_index;
      a_data_r <= in_sample_word;
      a_side_r <= side_c;
      a_px_r   <= P_W'(in_lon_frac) * P_W'(span);
      a_py_r   <= P_W'(in_lat_frac) * P_W'(span);
    end
  end

  // stage B: split position, row base offset
  assign ix  = a_px_r[P_W-1:FRAC_BITS];
  assign iy  = a_py_r[P_W-1:FRAC_BITS];
  assign frx = a_px_r[FRAC_BITS-1:0];
  assign fry = a_py_r[FRAC_BITS-1:0];
  assign row = a_side_r - SW'(1) - iy;

  if (FRAC_BITS >= WEIGHT_BITS) begin : g_wtrunc
    assign wx = frx[FRAC_BITS-1 -: WEIGHT_BITS];
    assign wy = fry[FRAC_BITS-1 -: WEIGHT_BITS];
  end else begin : g_wpad
    assign wx = {frx, {(WEIGHT_BITS - FRAC_BITS){1'b0}}};
    assign wy = {fry, {(WEIGHT_BITS - FRAC_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r && a_keep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld_r) begin
      b_kind_r <= a_kind_r;
      b_nt_r   <= a_nt_r;
      b_idx_r  <= a_idx_r;
      b_data_r <= a_data_r;
      b_side_r <= a_side_r;
      b_ix_r   <= ix;
      b_rowp_r <= R_W'(a_side_r) * R_W'(row);
      b_wx_r   <= wx;
      b_wy_r   <= wy;
    end
  end

  assign b_addr = (b_kind_r == etbs_pkg::KIND_QUERY) ?
                  ADDR_W'(b_rowp_r + R_W'(b_ix_r)) : ADDR_W'(b_idx_r);

  assign push      = b_vld_r;
  assign push_data = {b_kind_r, b_nt_r, b_side_r, b_data_r, b_wy_r, b_wx_r, b_addr};

  assign status.a_vld = a_vld_r;
  assign status.b_vld = b_vld_r;

endmodule

// ----- rtl/core/etbs_queue.sv -----
module etbs_queue #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     head_data,
  output etbs_pkg::q_status_t  status
);

  logic [WIDTH-1:0]               ent_r [etbs_pkg::QDEPTH];
  logic [etbs_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [etbs_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [etbs_pkg::QCNT_W-1:0]    count_r;
  logic [etbs_pkg::QCNT_W-1:0]    count_nxt;

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + etbs_pkg::QCNT_W'(1);
      2'b01:   count_nxt = count_r - etbs_pkg::QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + etbs_pkg::QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + etbs_pkg::QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data    = ent_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.count = count_r;

endmodule

// ----- rtl/core/etbs_back.sv -----
module etbs_back #(
  parameter int MAX_SIDE    = 1201,
  parameter int WEIGHT_BITS = 16,
  localparam int DEPTH      = MAX_SIDE * MAX_SIDE,
  localparam int ADDR_W     = $clog2(DEPTH),
  localparam int ENTRY_W    = ADDR_W + 2 * WEIGHT_BITS + etbs_pkg::SAMPLE_W
                              + etbs_pkg::SIDE_W + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ENTRY_W-1:0]            head_data,
  input  etbs_pkg::q_status_t           q_status,
  input  logic [etbs_pkg::SAMPLE_W-1:0] void_code,
  output logic                          pop,
  output logic                          out_valid,
  output logic signed [etbs_pkg::ALT_W-1:0] out_altitude,
  output logic                          out_is_void
);

  localparam int SW       = etbs_pkg::SIDE_W;
  localparam int DW       = etbs_pkg::SAMPLE_W;
  localparam int AW       = etbs_pkg::ALT_W;
  localparam int PROD_W   = AW + WEIGHT_BITS + 2;
  localparam int OFS_WX   = ADDR_W;
  localparam int OFS_WY   = OFS_WX + WEIGHT_BITS;
  localparam int OFS_DATA = OFS_WY + WEIGHT_BITS;
  localparam int OFS_SIDE = OFS_DATA + DW;
  localparam int OFS_NT   = OFS_SIDE + SW;
  localparam int OFS_KIND = OFS_NT + 1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2 ** (WEIGHT_BITS - 1));

  typedef struct packed {
    logic                 vd;
    logic signed [AW-1:0] v;
  } elev_t;

  function automatic logic signed [PROD_W-1:0] diff_mul(
    input logic signed [AW-1:0]  a,
    input logic signed [AW-1:0]  b,
    input logic [WEIGHT_BITS-1:0] w
  );
    logic signed [AW:0]          d;
    logic signed [WEIGHT_BITS:0] ws;
    d  = {b[AW-1], b} - {a[AW-1], a};
    ws = {1'b0, w};
    return d * ws;
  endfunction

  function automatic elev_t blend(
    input logic signed [AW-1:0]     a,
    input logic                     av,
    input logic signed [AW-1:0]     b,
    input logic                     bv,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0] rs;
    elev_t                    r;
    rs = (prod + ROUND_HALF) >>> WEIGHT_BITS;
    priority if (av) begin
      r.vd = bv;
      r.v  = b;
    end else if (bv) begin
      r.vd = 1'b0;
      r.v  = a;
    end else begin
      r.vd = 1'b0;
      r.v  = a + rs[AW-1:0];
    end
    return r;
  endfunction

  // sequencer
  etbs_pkg::seq_state_t state_r;
  etbs_pkg::seq_state_t state_nxt;
  logic                 can_pop;
  logic                 head_query;

  logic [ADDR_W-1:0]      cur_addr_r;
  logic [SW-1:0]          cur_side_r;
  logic [WEIGHT_BITS-1:0] cur_wx_r;
  logic [WEIGHT_BITS-1:0] cur_wy_r;
  logic                   cur_nt_r;
  logic [DW-1:0]          cur_data_r;

  logic                  mem_re;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  etbs_pkg::tap_t        tap;

  logic [DW-1:0]         mem [DEPTH];
  logic [DW-1:0]         rd_data_r;
  logic                  rd_vld_r;
  etbs_pkg::tap_t        rd_tap_r;
  logic [WEIGHT_BITS-1:0] rd_wx_r;
  logic [WEIGHT_BITS-1:0] rd_wy_r;
  logic                  rd_nt_r;

  logic signed [AW-1:0]  samp;
  logic                  svd;

  assign can_pop    = (state_r == etbs_pkg::SQ_IDLE) || (state_r == etbs_pkg::SQ_RD11) ||
                      (state_r == etbs_pkg::SQ_WR);
  assign pop        = can_pop && !q_status.empty;
  assign head_query = (head_data[OFS_KIND] == etbs_pkg::KIND_QUERY);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      etbs_pkg::SQ_RD00: state_nxt = etbs_pkg::SQ_RD10;
      etbs_pkg::SQ_RD10: state_nxt = etbs_pkg::SQ_RD01;
      etbs_pkg::SQ_RD01: state_nxt = etbs_pkg::SQ_RD11;
      etbs_pkg::SQ_IDLE, etbs_pkg::SQ_RD11, etbs_pkg::SQ_WR: begin
        if (pop) begin
          state_nxt = head_query ? etbs_pkg::SQ_RD00 : etbs_pkg::SQ_WR;
        end else begin
          state_nxt = etbs_pkg::SQ_IDLE;
        end
      end
      default: state_nxt = etbs_pkg::SQ_IDLE;
    endcase
  end

  always_comb begin
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = cur_addr_r;
    tap      = etbs_pkg::TAP_00;
    unique case (state_r)
      etbs_pkg::SQ_RD00: begin
        mem_re = 1'b1;
      end
      etbs_pkg::SQ_RD10: begin
        mem_re   = 1'b1;
        mem_addr = cur_addr_r + ADDR_W'(1);
        tap      = etbs_pkg::TAP_10;
      end
      etbs_pkg::SQ_RD01: begin
        mem_re   = 1'b1;
        mem_addr = cur_addr_r - ADDR_W'(cur_side_r);
        tap      = etbs_pkg::TAP_01;
      end
      etbs_pkg::SQ_RD11: begin
        mem_re   = 1'b1;
        mem_addr = cur_addr_r - ADDR_W'(cur_side_r) + ADDR_W'(1);
        tap      = etbs_pkg::TAP_11;
      end
      etbs_pkg::SQ_WR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= etbs_pkg::SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr_r <= head_data[ADDR_W-1:0];
      cur_wx_r   <= head_data[OFS_WX +: WEIGHT_BITS];
      cur_wy_r   <= head_data[OFS_WY +: WEIGHT_BITS];
      cur_data_r <= head_data[OFS_DATA +: DW];
      cur_side_r <= head_data[OFS_SIDE +: SW];
      cur_nt_r   <= head_data[OFS_NT];
    end
  end

  // tile memory, single port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= cur_data_r;
    end else if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_tap_r <= tap;
      rd_wx_r  <= cur_wx_r;
      rd_wy_r  <= cur_wy_r;
      rd_nt_r  <= cur_nt_r;
    end
  end

  assign samp = {rd_data_r, 8'h00};
  assign svd  = (rd_data_r == void_code);

  // blend pipeline
  logic signed [AW-1:0]     s00_r;
  logic                     s00v_r;
  logic signed [AW-1:0]     s01_r;
  logic                     s01v_r;
  logic signed [AW-1:0]     x0a_r;
  logic                     x0av_r;
  logic signed [AW-1:0]     x0b_r;
  logic                     x0bv_r;
  logic signed [PROD_W-1:0] p0_r;
  elev_t                    r0_r;
  elev_t                    r0;
  logic signed [AW-1:0]     x1a_r;
  logic                     x1av_r;
  logic signed [AW-1:0]     x1b_r;
  logic                     x1bv_r;
  logic signed [PROD_W-1:0] p1_r;
  logic [WEIGHT_BITS-1:0]   wy_r;
  logic                     nt_r;
  logic                     x_vld_r;
  elev_t                    r1_r;
  logic                     r_vld_r;
  logic signed [PROD_W-1:0] py_r;
  elev_t                    ya_r;
  elev_t                    yb_r;
  logic                     y_vld_r;
  elev_t                    fin;
  logic                     out_valid_r;
  logic signed [AW-1:0]     out_altitude_r;
  logic                     out_is_void_r;

  assign r0 = blend(x0a_r, x0av_r, x0b_r, x0bv_r, p0_r);

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      unique case (rd_tap_r)
        etbs_pkg::TAP_00: begin
          s00_r  <= samp;
          s00v_r <= svd;
        end
        etbs_pkg::TAP_10: begin
          p0_r   <= diff_mul(s00_r, samp, rd_wx_r);
          x0a_r  <= s00_r;
          x0av_r <= s00v_r;
          x0b_r  <= samp;
          x0bv_r <= svd;
        end
        etbs_pkg::TAP_01: begin
          r0_r   <= r0;
          s01_r  <= samp;
          s01v_r <= svd;
        end
        etbs_pkg::TAP_11: begin
          p1_r   <= diff_mul(s01_r, samp, rd_wx_r);
          x1a_r  <= s01_r;
          x1av_r <= s01v_r;
          x1b_r  <= samp;
          x1bv_r <= svd;
          wy_r   <= rd_wy_r;
          nt_r   <= rd_nt_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (x_vld_r) begin
      r1_r <= blend(x1a_r, x1av_r, x1b_r, x1bv_r, p1_r);
    end
    if (r_vld_r) begin
      py_r <= diff_mul(r0_r.v, r1_r.v, wy_r);
      ya_r <= r0_r;
      yb_r <= r1_r;
    end
  end

  assign fin = blend(ya_r.v, ya_r.vd, yb_r.v, yb_r.vd, py_r);

  always_ff @(posedge clk) begin
    if (y_vld_r) begin
      out_is_void_r  <= nt_r || fin.vd;
      out_altitude_r <= (nt_r || fin.vd) ? '0 : fin.v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r     <= 1'b0;
      r_vld_r     <= 1'b0;
      y_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      x_vld_r     <= rd_vld_r && (rd_tap_r == etbs_pkg::TAP_11);
      r_vld_r     <= x_vld_r;
      y_vld_r     <= r_vld_r;
      out_valid_r <= y_vld_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_altitude = out_altitude_r;
  assign out_is_void  = out_is_void_r;

endmodule

// ----- rtl/core/elevation_tile_bilinear_sampler.sv -----
// channel  | handshake           | words
// ---------+---------------------+--------------------------------------------------
// in       | start / busy        | in_kind, in_load_index, in_sample_word,
//          |                     | in_lat_frac, in_lon_frac
// out      | out_valid strobe    | out_altitude, out_is_void (no word for loads)
// cfg      | cfg_we              | cfg_index, cfg_wdata
//
// Queries: each holds the back end for the four reads of the single-port tile memory.
// Loads: one per cycle unless held by busy or by a query's reads.
// Reset clears control only; tile memory contents are undefined until loaded.
// busy rises when the front pipe plus queue could not take another word.
// The result side cannot stall: each out_valid pulse lasts one cycle.
module elevation_tile_bilinear_sampler #(
  parameter int MAX_SIDE    = 1201,
  parameter int FRAC_BITS   = 20,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic [20:0]                     in_load_index,
  input  logic [etbs_pkg::SAMPLE_W-1:0]   in_sample_word,
  input  logic [FRAC_BITS-1:0]            in_lat_frac,
  input  logic [FRAC_BITS-1:0]            in_lon_frac,
  output logic                            out_valid,
  output logic signed [etbs_pkg::ALT_W-1:0] out_altitude,
  output logic                            out_is_void,
  input  logic                            cfg_we,
  input  logic [etbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W  = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int ENTRY_W = ADDR_W + 2 * WEIGHT_BITS + etbs_pkg::SAMPLE_W
                           + etbs_pkg::SIDE_W + 2;
  localparam int OCC_W   = etbs_pkg::QCNT_W + 1;

  logic [etbs_pkg::SIDE_W-1:0]   tile_side_r;
  logic                          tile_present_r;
  logic [etbs_pkg::SAMPLE_W-1:0] void_code_r;

  logic                 accept;
  logic                 push;
  logic [ENTRY_W-1:0]   push_data;
  logic                 pop;
  logic [ENTRY_W-1:0]   head_data;
  etbs_pkg::fe_status_t fe_status;
  etbs_pkg::q_status_t  q_status;
  logic [OCC_W-1:0]     occ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_side_r    <= etbs_pkg::SIDE_RESET;
      tile_present_r <= 1'b0;
      void_code_r    <= etbs_pkg::VOID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        etbs_pkg::REG_TILE_SIDE:    tile_side_r    <= cfg_wdata[etbs_pkg::SIDE_W-1:0];
        etbs_pkg::REG_TILE_PRESENT: tile_present_r <= cfg_wdata[0];
        etbs_pkg::REG_VOID_CODE:    void_code_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign occ    = OCC_W'(q_status.count) + OCC_W'(fe_status.a_vld) + OCC_W'(fe_status.b_vld);
  assign busy   = (occ >= OCC_W'(etbs_pkg::QDEPTH));
  assign accept = start && !busy;

  etbs_front #(
    .MAX_SIDE    (MAX_SIDE),
    .FRAC_BITS   (FRAC_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_kind        (in_kind),
    .in_load_index  (in_load_index),
    .in_sample_word (in_sample_word),
    .in_lat_frac    (in_lat_frac),
    .in_lon_frac    (in_lon_frac),
    .tile_side      (tile_side_r),
    .tile_present   (tile_present_r),
    .push           (push),
    .push_data      (push_data),
    .status         (fe_status)
  );

  etbs_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (q_status)
  );

  etbs_back #(
    .MAX_SIDE    (MAX_SIDE),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_data    (head_data),
    .q_status     (q_status),
    .void_code    (void_code_r),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_altitude (out_altitude),
    .out_is_void  (out_is_void)
  );

endmodule

// ----- rtl/core/etbs_checker.sv -----
module etbs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic signed [etbs_pkg::ALT_W-1:0] out_altitude,
  input logic                             out_is_void
);

  // nothing pending right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("result or busy right after reset");

  // void words carry zero altitude
  a_void_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_void |-> out_altitude == '0)
    else $error("void word with nonzero altitude");

  // each query holds the tile memory for four reads
  a_word_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result words closer than four cycles");

  // occupancy only grows through an accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted word");

endmodule

bind elevation_tile_bilinear_sampler etbs_checker u_etbs_checker (.*);

// ----- test/elevation_tile_bilinear_sampler_test.sv -----
module elevation_tile_bilinear_sampler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIDE    = 1201;
  localparam int FRAC_BITS   = 20;
  localparam int WEIGHT_BITS = 16;
  localparam int TILE_DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int SETTLE      = 32;
  localparam int ITEMS       = 1300;
  localparam int SIDE_W      = etbs_pkg::SIDE_W;
  localparam int SAMPLE_W    = etbs_pkg::SAMPLE_W;
  localparam int ALT_W       = etbs_pkg::ALT_W;
  localparam int CFG_IDX_W   = etbs_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = etbs_pkg::CFG_DATA_W;
  localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;

  typedef enum logic {ROW_WORD, ROW_REG} row_op_t;

  typedef struct {
    row_op_t                op;
    logic                   kind;
    logic [20:0]            idx;
    logic [SAMPLE_W-1:0]    word;
    logic [FRAC_BITS-1:0]   lat;
    logic [FRAC_BITS-1:0]   lon;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    bit                     fixed;
    logic signed [ALT_W-1:0] alt;
    logic                   vd;
  } script_row_t;

  typedef struct {
    longint v;
    bit     vd;
  } elev_t;

  typedef struct {
    logic signed [ALT_W-1:0] alt;
    logic                    vd;
  } alt_word_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_kind = 1'b0;
  logic [20:0]                   in_load_index = '0;
  logic [SAMPLE_W-1:0]           in_sample_word = '0;
  logic [FRAC_BITS-1:0]          in_lat_frac = '0;
  logic [FRAC_BITS-1:0]          in_lon_frac = '0;
  logic                          out_valid;
  logic signed [ALT_W-1:0]       out_altitude;
  logic                          out_is_void;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata = '0;

  logic [SIDE_W-1:0]   side_reg = etbs_pkg::SIDE_RESET;
  logic                present_reg = 1'b0;
  logic [SAMPLE_W-1:0] void_reg = etbs_pkg::VOID_RESET;

  logic [SAMPLE_W-1:0] tile_copy [TILE_DEPTH];
  bit                  tile_seen [TILE_DEPTH];

  alt_word_t altitude_q [$];
  int        words_taken = 0;
  int        errors = 0;
  bit        burst = 1'b0;

  elevation_tile_bilinear_sampler #(
    .MAX_SIDE   (MAX_SIDE),
    .FRAC_BITS  (FRAC_BITS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_load_index (in_load_index),
    .in_sample_word(in_sample_word),
    .in_lat_frac   (in_lat_frac),
    .in_lon_frac   (in_lon_frac),
    .out_valid     (out_valid),
    .out_altitude  (out_altitude),
    .out_is_void   (out_is_void),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned eff_side();
    if (side_reg < etbs_pkg::SIDE_MIN) return 32'(etbs_pkg::SIDE_MIN);
    if (32'(side_reg) > MAX_SIDE) return MAX_SIDE;
    return 32'(side_reg);
  endfunction

  function automatic void split_pos(input logic [FRAC_BITS-1:0] f, input int unsigned span,
                                    output int unsigned ip, output longint w);
    longint unsigned p;
    p = 64'(f) * 64'(span);
    ip = int'(p >> FRAC_BITS);
    w = longint'((p & ((64'd1 << FRAC_BITS) - 1)) >> (FRAC_BITS - WEIGHT_BITS));
  endfunction

  function automatic int unsigned tap_addr(int unsigned s, int unsigned col,
                                           int unsigned row_s);
    return col + s * (s - 1 - row_s);
  endfunction

  function automatic elev_t read_tap(int unsigned s, int unsigned col, int unsigned row_s);
    elev_t e;
    logic [SAMPLE_W-1:0] raw;
    raw = tile_copy[tap_addr(s, col, row_s)];
    e.vd = (raw == void_reg);
    e.v = longint'(signed'(raw)) * 256;
    return e;
  endfunction

  // a void operand yields the other one unchanged
  function automatic elev_t mix(elev_t a, elev_t b, longint w);
    elev_t r;
    if (a.vd) return b;
    if (b.vd) return a;
    r.vd = 1'b0;
    r.v = (a.v * ((64'sd1 <<< WEIGHT_BITS) - w) + b.v * w
           + (64'sd1 <<< (WEIGHT_BITS - 1))) >>> WEIGHT_BITS;
    return r;
  endfunction

  function automatic alt_word_t predict_altitude(logic [FRAC_BITS-1:0] lat,
                                                 logic [FRAC_BITS-1:0] lon);
    alt_word_t res;
    elev_t r;
    int unsigned s, ix, iy;
    longint wx, wy;
    res.alt = '0;
    res.vd = 1'b1;
    if (!present_reg) return res;
    s = eff_side();
    split_pos(lon, s - 1, ix, wx);
    split_pos(lat, s - 1, iy, wy);
    r = mix(mix(read_tap(s, ix, iy), read_tap(s, ix + 1, iy), wx),
            mix(read_tap(s, ix, iy + 1), read_tap(s, ix + 1, iy + 1), wx), wy);
    if (!r.vd) begin
      res.alt = ALT_W'(r.v);
      res.vd = 1'b0;
    end
    return res;
  endfunction

  function automatic void take_word(logic kind, logic [20:0] idx, logic [SAMPLE_W-1:0] word,
                                    logic [FRAC_BITS-1:0] lat, logic [FRAC_BITS-1:0] lon);
    if (kind == etbs_pkg::KIND_LOAD) begin
      if (idx < TILE_DEPTH) begin
        tile_copy[idx] = word;
        tile_seen[idx] = 1'b1;
      end
      words_taken++;
    end else begin
      altitude_q.push_back(predict_altitude(lat, lon));
      words_taken++;
    end
  endfunction

  function automatic int pick_gap();
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [FRAC_BITS-1:0] pick_frac();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FRAC_MAX;
      2: return FRAC_BITS'($urandom_range(0, 255));
      default: return FRAC_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] fresh_sample();
    return ($urandom_range(0, 3) == 0) ? void_reg : SAMPLE_W'($urandom);
  endfunction

  function automatic logic [20:0] pick_addr();
    int unsigned s;
    s = eff_side();
    if (s * s <= 4096 && $urandom_range(0, 3) != 0) return 21'($urandom_range(0, s * s - 1));
    return 21'($urandom_range(0, TILE_DEPTH - 1));
  endfunction

  function automatic script_row_t word_row(logic kind, logic [20:0] idx,
                                           logic [SAMPLE_W-1:0] word,
                                           logic [FRAC_BITS-1:0] lat,
                                           logic [FRAC_BITS-1:0] lon, bit fixed,
                                           logic signed [ALT_W-1:0] alt, logic vd);
    script_row_t r;
    r.op = ROW_WORD;
    r.kind = kind;
    r.idx = idx;
    r.word = word;
    r.lat = lat;
    r.lon = lon;
    r.reg_idx = '0;
    r.reg_data = '0;
    r.fixed = fixed;
    r.alt = alt;
    r.vd = vd;
    return r;
  endfunction

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r = word_row(etbs_pkg::KIND_LOAD, '0, '0, '0, '0, 1'b0, '0, 1'b0);
    r.op = ROW_REG;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  task automatic report_bad(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic push_word(logic kind, logic [20:0] idx, logic [SAMPLE_W-1:0] word,
                           logic [FRAC_BITS-1:0] lat, logic [FRAC_BITS-1:0] lon);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_load_index <= idx;
    in_sample_word <= word;
    in_lat_frac <= lat;
    in_lon_frac <= lon;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic load_word(logic [20:0] addr, logic [SAMPLE_W-1:0] w);
    logic [FRAC_BITS-1:0] lat, lon;
    lat = pick_frac();
    lon = pick_frac();
    push_word(etbs_pkg::KIND_LOAD, addr, w, lat, lon);
    take_word(etbs_pkg::KIND_LOAD, addr, w, lat, lon);
  endtask

  // loads the four taps first when unwritten, and now and then anyway
  task automatic query_with_taps(logic [FRAC_BITS-1:0] lat, logic [FRAC_BITS-1:0] lon);
    int unsigned s, ix, iy, a;
    longint wx, wy;
    logic [20:0] idx;
    logic [SAMPLE_W-1:0] word;
    s = eff_side();
    split_pos(lon, s - 1, ix, wx);
    split_pos(lat, s - 1, iy, wy);
    for (int t = 0; t < 4; t++) begin
      a = tap_addr(s, ix + t % 2, iy + t / 2);
      if (!tile_seen[a] || $urandom_range(0, 3) == 0) load_word(21'(a), fresh_sample());
    end
    idx = 21'($urandom);
    word = SAMPLE_W'($urandom);
    push_word(etbs_pkg::KIND_QUERY, idx, word, lat, lon);
    take_word(etbs_pkg::KIND_QUERY, idx, word, lat, lon);
  endtask

  task automatic drain_block();
    start <= 1'b0;
    while (altitude_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      etbs_pkg::REG_TILE_SIDE:    side_reg = data[SIDE_W-1:0];
      etbs_pkg::REG_TILE_PRESENT: present_reg = data[0];
      etbs_pkg::REG_VOID_CODE:    void_reg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic pick_setting(int phase);
    logic [SIDE_W-1:0] s;
    logic [SAMPLE_W-1:0] v;
    logic p;
    case (phase)
      0: s = SIDE_W'(MAX_SIDE);
      1: s = etbs_pkg::SIDE_MIN;
      2: s = '1;
      3: s = '0;
      default: begin
        case ($urandom_range(0, 7))
          0: s = SIDE_W'($urandom_range(0, 1));
          1: s = SIDE_W'($urandom_range(MAX_SIDE + 1, 2047));
          2: s = SIDE_W'(MAX_SIDE);
          3: s = SIDE_W'($urandom_range(2, MAX_SIDE));
          default: s = SIDE_W'($urandom_range(2, 12));
        endcase
      end
    endcase
    p = (phase == 4) ? 1'b0 : ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 3))
      0: v = etbs_pkg::VOID_RESET;
      1: v = 16'h7FFF;
      2: v = '0;
      default: v = SAMPLE_W'($urandom);
    endcase
    write_reg(etbs_pkg::REG_TILE_SIDE, {5'($urandom), s});
    write_reg(etbs_pkg::REG_TILE_PRESENT, {15'($urandom), p});
    write_reg(etbs_pkg::REG_VOID_CODE, v);
    burst = ($urandom_range(0, 3) == 0);
  endtask

  always @(posedge clk) begin : watch_results
    alt_word_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (altitude_q.size() == 0) begin
        report_bad("result word with nothing pending");
      end else begin
        want = altitude_q.pop_front();
        if (out_is_void !== want.vd)
          report_bad($sformatf("is_void got %b want %b", out_is_void, want.vd));
        if (out_altitude !== want.alt)
          report_bad($sformatf("altitude got %0d want %0d", out_altitude, want.alt));
      end
    end
  end

  initial begin : stimulus
    script_row_t script [$];
    script_row_t r;
    alt_word_t typed;
    int target;
    int phase;
    int pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: no tile, queries come back void
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, '0, '0, 1'b1, '0, 1'b1));
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, FRAC_MAX, FRAC_MAX, 1'b1, '0,
                              1'b1));
    script.push_back(word_row(etbs_pkg::KIND_LOAD, 21'h1FFFFF, 16'hFFFF, '0, '0, 1'b0, '0,
                              1'b0));
    script.push_back(word_row(etbs_pkg::KIND_LOAD, 21'(TILE_DEPTH), 16'h1234, '0, '0, 1'b0,
                              '0, 1'b0));
    script.push_back(word_row(etbs_pkg::KIND_LOAD, 21'(TILE_DEPTH - 1), 16'h7FFF, '0, '0,
                              1'b0, '0, 1'b0));
    script.push_back(reg_row(etbs_pkg::REG_TILE_SIDE, 16'd2));
    script.push_back(reg_row(etbs_pkg::REG_TILE_PRESENT, 16'd1));
    script.push_back(word_row(etbs_pkg::KIND_LOAD, 21'd0, 16'h7FFF, '0, '0, 1'b0, '0, 1'b0));
    script.push_back(word_row(etbs_pkg::KIND_LOAD, 21'd1, 16'h8000, '0, '0, 1'b0, '0, 1'b0));
    script.push_back(word_row(etbs_pkg::KIND_LOAD, 21'd2, 16'h8001, '0, '0, 1'b0, '0, 1'b0));
    script.push_back(word_row(etbs_pkg::KIND_LOAD, 21'd3, 16'h0064, '0, '0, 1'b0, '0, 1'b0));
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, '0, '0, 1'b1, -24'sd8388352,
                              1'b0));
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, '0, FRAC_MAX, 1'b0, '0, 1'b0));
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, FRAC_MAX, '0, 1'b0, '0, 1'b0));
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, 20'h80000, 20'h80000, 1'b0, '0,
                              1'b0));
    script.push_back(reg_row(etbs_pkg::REG_VOID_CODE, 16'h7FFF));
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, FRAC_MAX, '0, 1'b0, '0, 1'b0));
    script.push_back(word_row(etbs_pkg::KIND_LOAD, 21'd2, 16'h7FFF, '0, '0, 1'b0, '0, 1'b0));
    script.push_back(word_row(etbs_pkg::KIND_LOAD, 21'd3, 16'h7FFF, '0, '0, 1'b0, '0, 1'b0));
    // south row all void, north row one void: the valid sample passes through
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, '0, '0, 1'b1, -24'sd8388608,
                              1'b0));
    script.push_back(word_row(etbs_pkg::KIND_LOAD, 21'd1, 16'h7FFF, '0, '0, 1'b0, '0, 1'b0));
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, 20'h12345, 20'h54321, 1'b1, '0,
                              1'b1));
    script.push_back(reg_row(etbs_pkg::REG_TILE_SIDE, 16'd1));
    script.push_back(reg_row(etbs_pkg::REG_VOID_CODE, etbs_pkg::VOID_RESET));
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, FRAC_MAX, FRAC_MAX, 1'b1,
                              24'sd8388352, 1'b0));
    script.push_back(reg_row(etbs_pkg::REG_TILE_PRESENT, 16'd0));
    script.push_back(word_row(etbs_pkg::KIND_QUERY, '0, '0, 20'h00001, 20'hFFFFE, 1'b1, '0,
                              1'b1));

    foreach (script[i]) begin
      r = script[i];
      if (r.op == ROW_REG) begin
        drain_block();
        write_reg(r.reg_idx, r.reg_data);
      end else begin
        push_word(r.kind, r.idx, r.word, r.lat, r.lon);
        if (r.fixed) begin
          typed.alt = r.alt;
          typed.vd = r.vd;
          altitude_q.push_back(typed);
        end else begin
          take_word(r.kind, r.idx, r.word, r.lat, r.lon);
        end
      end
    end

    words_taken = 0;
    phase = 0;
    while (words_taken < ITEMS) begin
      drain_block();
      pick_setting(phase);
      phase++;
      target = words_taken + $urandom_range(60, 120);
      while (words_taken < target) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) query_with_taps(pick_frac(), pick_frac());
        else if (pick < 17) load_word(pick_addr(), fresh_sample());
        else load_word(21'($urandom_range(TILE_DEPTH, 21'h1FFFFF)), SAMPLE_W'($urandom));
      end
    end

    drain_block();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
